[rtl/rchp_pkg.sv]
// shared types and constants of the radio chatter high-pass filter
// no dependencies
package rchp_pkg;

  localparam logic [7:0] Silence    = 8'h80;
  localparam int         Window     = 4;
  localparam int         QueueDepth = 4;
  localparam int         AddrW      = 3;
  localparam int         DataW      = 32;

  // register index as taken from paddr
  localparam logic RegFilterEnable = 1'b0;

  // one command from the front to the back: an optional data item, then pads
  typedef struct packed {
    logic       data_vld;
    logic [7:0] data;
    logic       data_last;
    logic [2:0] pad_cnt;
  } cmd_t;

endpackage

[rtl/rchp_in_if.sv]
// input channel of the filter: sample and end-of-buffer mark
// no dependencies
interface rchp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_in;
  logic       buffer_last;

  modport source (output valid, output sample_in, output buffer_last, input ready);
  modport sink   (input valid, input sample_in, input buffer_last, output ready);
endinterface

[rtl/rchp_out_if.sv]
// output channel of the filter: sample and end-of-buffer mark
// no dependencies
interface rchp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_out;
  logic       out_last;

  modport source (output valid, output sample_out, output out_last, input ready);
  modport sink   (input valid, input sample_out, input out_last, output ready);
endinterface

[rtl/radio_chatter_highpass_filter.sv]
// top level of the radio chatter high-pass filter: config register, front, queue, back
// depends on rchp_pkg, rchp_in_if, rchp_out_if, rchp_front, rchp_fifo, rchp_back
//
//   channel   dir  handshake      payload
//   in_ch     in   valid/ready    sample_in[7:0], buffer_last
//   out_ch    out  valid/ready    sample_out[7:0], out_last
//   apb       in   psel/penable   paddr[2:0], pwdata[31:0], prdata[31:0]
//
// one sample is taken per cycle while the command queue has room
// a sample gives at most one result, none while the window fills, the last of a buffer up to five; the back end
// emits one result per cycle while the output is ready
// a result passes through the command queue, the held command register and the output register
// reset clears the window, the queue pointers, the held and output valid flags and filter_enable
module radio_chatter_highpass_filter #(
  parameter int QueueDepth = rchp_pkg::QueueDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rchp_in_if.sink                    in_ch,
  rchp_out_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [rchp_pkg::AddrW-1:0] paddr,
  input  logic [rchp_pkg::DataW-1:0] pwdata,
  output logic [rchp_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import rchp_pkg::*;

  logic enable_q;
  logic push, pop, full, empty;
  cmd_t cmd, head;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegFilterEnable) ? {{(DataW-1){1'b0}}, enable_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == RegFilterEnable)) begin
      enable_q <= pwdata[0];
    end
  end

  rchp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .enable_i    (enable_q),
    .in_valid_i  (in_ch.valid),
    .in_sample_i (in_ch.sample_in),
    .in_last_i   (in_ch.buffer_last),
    .in_ready_o  (in_ch.ready),
    .full_i      (full),
    .push_o      (push),
    .cmd_o       (cmd)
  );

  rchp_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  rchp_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .out_valid_o  (out_ch.valid),
    .out_ready_i  (out_ch.ready),
    .out_sample_o (out_ch.sample_out),
    .out_last_o   (out_ch.out_last)
  );

endmodule

[rtl/rchp_front.sv]
// front end: accepts samples, keeps the four-sample window, builds commands
// depends on rchp_pkg
module rchp_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          enable_i,
  input  logic          in_valid_i,
  input  logic [7:0]    in_sample_i,
  input  logic          in_last_i,
  output logic          in_ready_o,
  input  logic          full_i,
  output logic          push_o,
  output rchp_pkg::cmd_t cmd_o
);
  import rchp_pkg::*;

  logic [7:0]        delay_q [Window];
  logic [7:0]        delay_d [Window];
  logic signed [9:0] sum_q, sum_d;
  logic [2:0]        fill_q, fill_d;
  logic              accept;
  logic [7:0]        oldest;
  logic signed [9:0] sum_adj;
  logic signed [9:0] mean_w;
  logic [7:0]        diff;
  logic [7:0]        filt;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;
  assign oldest     = delay_q[0];

  // mean rounded toward zero
  assign sum_adj = sum_q[9] ? sum_q + 10'sd3 : sum_q;
  assign mean_w  = sum_adj >>> 2;
  assign diff    = oldest - mean_w[7:0];
  assign filt    = {diff[6:0], 1'b0} + Silence;

  always_comb begin
    delay_d = delay_q;
    sum_d   = sum_q;
    fill_d  = fill_q;
    cmd_o   = '0;
    if (!enable_i) begin
      cmd_o.data_vld  = 1'b1;
      cmd_o.data      = in_sample_i;
      cmd_o.data_last = in_last_i;
      for (int k = 0; k < Window; k++) delay_d[k] = '0;
      sum_d  = '0;
      fill_d = '0;
    end else begin
      if (fill_q[2]) begin
        cmd_o.data_vld = 1'b1;
        cmd_o.data     = filt;
        sum_d = sum_q + $signed({2'b00, in_sample_i}) - $signed({2'b00, oldest});
        for (int k = 0; k < Window - 1; k++) delay_d[k] = delay_q[k + 1];
        delay_d[Window - 1] = in_sample_i;
      end else begin
        delay_d[fill_q[1:0]] = in_sample_i;
        sum_d  = sum_q + $signed({2'b00, in_sample_i}) - $signed({2'b00, Silence});
        fill_d = fill_q + 3'd1;
      end
      if (in_last_i) begin
        // one pad for each sample still held in the window
        cmd_o.pad_cnt = fill_d;
        for (int k = 0; k < Window; k++) delay_d[k] = '0;
        sum_d  = '0;
        fill_d = '0;
      end
    end
  end

  assign push_o = accept && (cmd_o.data_vld || (cmd_o.pad_cnt != 3'd0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Window; k++) delay_q[k] <= '0;
      sum_q  <= '0;
      fill_q <= '0;
    end else if (accept) begin
      delay_q <= delay_d;
      sum_q   <= sum_d;
      fill_q  <= fill_d;
    end
  end

  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= 3'd4)
    else $error("window fill beyond four samples");

  a_disabled_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !enable_i) |=> (fill_q == 3'd0 && sum_q == 10'sd0))
    else $error("window not cleared while bypassed");

endmodule

[rtl/rchp_fifo.sv]
// command queue between front and back
// depends on rchp_pkg
module rchp_fifo #(
  parameter int Depth = rchp_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rchp_pkg::cmd_t data_i,
  input  logic           pop_i,
  output rchp_pkg::cmd_t head_o,
  output logic           full_o,
  output logic           empty_o
);
  import rchp_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign head_o  = mem_q[rptr_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= nxt(wptr_q);
      if (pop_i) rptr_q <= nxt(rptr_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("command pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i)
    else $error("command popped from empty queue");

endmodule

[rtl/rchp_back.sv]
// back end: expands commands into result items behind an output register
// depends on rchp_pkg
module rchp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rchp_pkg::cmd_t head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_sample_o,
  output logic           out_last_o
);
  import rchp_pkg::*;

  cmd_t       cur_q, cur_d, rest;
  logic       cur_vld_q, cur_vld_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_smp_q, out_smp_d;
  logic       out_lst_q, out_lst_d;
  logic       advance;
  logic       remaining;

  assign advance = cur_vld_q && (!out_vld_q || out_ready_i);

  // data item first, then the pads; the final pad carries the mark, a data item carries its own data_last
  always_comb begin
    rest = cur_q;
    if (cur_q.data_vld) begin
      out_smp_d     = cur_q.data;
      out_lst_d     = cur_q.data_last;
      rest.data_vld = 1'b0;
    end else begin
      out_smp_d    = Silence;
      out_lst_d    = (cur_q.pad_cnt == 3'd1);
      rest.pad_cnt = cur_q.pad_cnt - 3'd1;
    end
  end

  assign remaining = rest.data_vld || (rest.pad_cnt != 3'd0);
  assign pop_o     = !empty_i && (!cur_vld_q || (advance && !remaining));

  always_comb begin
    cur_d     = cur_q;
    cur_vld_d = cur_vld_q;
    if (pop_o) begin
      cur_d     = head_i;
      cur_vld_d = 1'b1;
    end else if (advance) begin
      cur_d     = rest;
      cur_vld_d = remaining;
    end
    if (advance) out_vld_d = 1'b1;
    else if (out_ready_i) out_vld_d = 1'b0;
    else out_vld_d = out_vld_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      cur_vld_q <= cur_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (advance) begin
      out_smp_q <= out_smp_d;
      out_lst_q <= out_lst_d;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sample_o = out_smp_q;
  assign out_last_o   = out_lst_q;

  a_cur_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (cur_q.data_vld || (cur_q.pad_cnt != 3'd0)))
    else $error("held command has nothing left to emit");

  a_pad_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_vld_q |-> (cur_q.pad_cnt <= 3'd4))
    else $error("pad count beyond window size");

endmodule
